@@ hdl/sfla_pkg.sv @@
// Package with the shared types and constants of the slot allocator.
`timescale 1ns / 1ps

package sfla_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int INDEX_SPAN = 1024;

    localparam logic [10:0] MAX_ENTRIES_RST = 11'd1024;
    localparam logic [10:0] END_MARK = 11'h7FF;
    localparam logic [10:0] USED_RST = 11'd1;

    localparam logic [1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [1:0] KIND_FREE = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [9:0] acquired_index;
        logic [1:0] status;
        logic       is_deleted;
    } t_out_item;

    // Control from the sequencer to the core: issue starts the link read,
    // commit applies the update and produces the result.
    typedef struct packed {
        logic issue;
        logic commit;
    } t_ctl;

endpackage

@@ hdl/slot_free_list_allocator.sv @@
// Top level of the slot allocator: input register, sequencer and result register.
//
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+--------------------------------
//  in      | input     | i_in_valid / o_in_ready   | t_in_item: kind, slot_index
//  out     | output    | o_out_valid / i_out_ready | t_out_item: index, status, flag
//  cfg     | input     | i_cfg_valid / o_cfg_ready | max_entries, 11 bits
//
// Each item first reads the link store when it is accepted in S_IDLE, then updates the
// list and loads the result register in S_EXEC. The registered read of the link memory separates the two steps.
// A new beat is taken while an earlier result still waits in the result register;
// the item then holds in S_EXEC until that result is taken.
// Synchronous active-low reset empties the free list and restarts the bump counter at one.
`timescale 1ns / 1ps

module slot_free_list_allocator #(
    parameter int CAPACITY = sfla_pkg::CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  sfla_pkg::t_in_item   i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output sfla_pkg::t_out_item  o_out_item,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [10:0]          i_cfg_data
);

    import sfla_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state    r_state;
    t_in_item  r_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_ctl      ctl;
    t_out_item result;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign ctl.issue  = i_in_valid && o_in_ready;
    assign ctl.commit = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    sfla_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_new_item (i_in_item),
        .i_cur_item (r_item),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (ctl.issue) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (ctl.commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (ctl.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (ctl.issue) begin
            r_item <= i_in_item;
        end
        if (ctl.commit) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ hdl/sfla_ram.sv @@
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module sfla_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/sfla_core.sv @@
// Allocator core: list head, bump counter, limit register, link store and update logic.
`timescale 1ns / 1ps

module sfla_core #(
    parameter int CAPACITY = sfla_pkg::CAPACITY_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sfla_pkg::t_ctl       i_ctl,
    input  sfla_pkg::t_in_item   i_new_item,
    input  sfla_pkg::t_in_item   i_cur_item,
    input  logic                 i_cfg_we,
    input  logic [10:0]          i_cfg_data,
    output sfla_pkg::t_out_item  o_result
);

    import sfla_pkg::*;

    localparam int DEPTH = (CAPACITY < INDEX_SPAN) ? CAPACITY : INDEX_SPAN;
    localparam int AW = $clog2(DEPTH);
    localparam logic [10:0] LIMIT_CAP = 11'(DEPTH);

    logic [10:0] r_free_head, n_free_head;
    logic [10:0] r_used_count, n_used_count;
    logic [10:0] r_max_entries;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [10:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [10:0]   ram_rdata;

    logic [10:0] limit;
    logic        head_ok;
    logic        idx_ok;
    t_out_item   result;

    // Acquire reads the link of the current head; free and query read their own slot.
    assign ram_raddr = (i_new_item.kind == KIND_ACQUIRE) ? r_free_head[AW-1:0]
                                                          : i_new_item.slot_index[AW-1:0];

    sfla_ram #(
        .WIDTH (11),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_ctl.issue),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign limit = (r_max_entries > LIMIT_CAP) ? LIMIT_CAP : r_max_entries;

    assign head_ok = (r_free_head != 11'd0) && (r_free_head != END_MARK)
                     && (32'(r_free_head) < 32'(CAPACITY));

    assign idx_ok = (i_cur_item.slot_index != 10'd0)
                    && ({1'b0, i_cur_item.slot_index} < r_used_count)
                    && (32'(i_cur_item.slot_index) < 32'(CAPACITY));

    always_comb begin
        result       = '0;
        result.status = ST_OK;
        n_free_head  = r_free_head;
        n_used_count = r_used_count;
        ram_we       = 1'b0;
        ram_waddr    = i_cur_item.slot_index[AW-1:0];
        ram_wdata    = 11'd0;
        case (i_cur_item.kind)
            KIND_ACQUIRE: begin
                if (head_ok) begin
                    result.acquired_index = r_free_head[9:0];
                    n_free_head = ram_rdata;
                    ram_we      = 1'b1;
                    ram_waddr   = r_free_head[AW-1:0];
                end else if (r_used_count >= limit) begin
                    result.status = ST_FULL;
                end else begin
                    result.acquired_index = r_used_count[9:0];
                    n_used_count = r_used_count + 11'd1;
                    ram_we       = 1'b1;
                    ram_waddr    = r_used_count[AW-1:0];
                end
            end
            KIND_FREE: begin
                if (idx_ok) begin
                    ram_we      = 1'b1;
                    ram_wdata   = r_free_head;
                    n_free_head = {1'b0, i_cur_item.slot_index};
                end else begin
                    result.status = ST_INVALID;
                end
            end
            KIND_QUERY: begin
                if (idx_ok) begin
                    result.is_deleted = (ram_rdata != 11'd0);
                end else begin
                    result.status = ST_INVALID;
                end
            end
            default: begin
                result.status = ST_INVALID;
            end
        endcase
        ram_we = ram_we & i_ctl.commit;
    end

    assign o_result = result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head   <= END_MARK;
            r_used_count  <= USED_RST;
            r_max_entries <= MAX_ENTRIES_RST;
        end else begin
            if (i_ctl.commit) begin
                r_free_head  <= n_free_head;
                r_used_count <= n_used_count;
            end
            if (i_cfg_we) begin
                r_max_entries <= i_cfg_data;
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the slot free-list allocator with its own allocation predictor.
`timescale 1ns / 1ps

module testbench;
    import sfla_pkg::*;

    localparam logic [10:0] SLOT_SPAN = 11'(INDEX_SPAN);

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [10:0] i_cfg_data = '0;

    // Predicted allocator state.
    logic [10:0] link_word [0:INDEX_SPAN-1];
    logic [10:0] list_head = END_MARK;
    logic [10:0] next_fresh = USED_RST;
    logic [10:0] entry_limit = MAX_ENTRIES_RST;

    t_out_item   pending_outcomes[$];
    logic [9:0]  held_slots[$];
    int          mismatch_count = 0;
    int          in_idle_pct = 12;
    int          out_idle_pct = 12;
    int          out_hold_left = 0;

    slot_free_list_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic t_out_item alloc_outcome(t_in_item op);
        t_out_item   res;
        logic [10:0] lim;
        logic [10:0] nxt;
        logic        ok_index;
        res = '0;
        res.status = ST_OK;
        lim = (entry_limit > SLOT_SPAN) ? SLOT_SPAN : entry_limit;
        ok_index = (op.slot_index != 10'd0) && ({1'b0, op.slot_index} < next_fresh);
        case (op.kind)
            KIND_ACQUIRE: begin
                // A head of zero can only come from a double free and reads as empty.
                if (list_head != 11'd0 && list_head != END_MARK && list_head < SLOT_SPAN) begin
                    res.acquired_index = list_head[9:0];
                    nxt = link_word[list_head];
                    link_word[list_head] = 11'd0;
                    list_head = nxt;
                end else if (next_fresh >= lim) begin
                    res.status = ST_FULL;
                end else begin
                    res.acquired_index = next_fresh[9:0];
                    link_word[next_fresh] = 11'd0;
                    next_fresh = next_fresh + 11'd1;
                end
            end
            KIND_FREE: begin
                if (ok_index) begin
                    link_word[op.slot_index] = list_head;
                    list_head = {1'b0, op.slot_index};
                end else begin
                    res.status = ST_INVALID;
                end
            end
            KIND_QUERY: begin
                if (ok_index) begin
                    res.is_deleted = (link_word[op.slot_index] != 11'd0);
                end else begin
                    res.status = ST_INVALID;
                end
            end
            default: res.status = ST_INVALID;
        endcase
        return res;
    endfunction

    // Receiver: random ready, with a long hold-off when a test asks for one.
    always @(posedge i_clk) begin
        if (out_hold_left > 0) begin
            out_hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("MISMATCH at %0t: unexpected result %p", $realtime, o_out_item);
            end else begin
                want = pending_outcomes.pop_front();
                if (o_out_item.acquired_index !== want.acquired_index ||
                    o_out_item.status !== want.status ||
                    o_out_item.is_deleted !== want.is_deleted) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("MISMATCH at %0t: index %0d/%0d status %0d/%0d deleted %0d/%0d",
                                 $realtime, want.acquired_index, o_out_item.acquired_index,
                                 want.status, o_out_item.status,
                                 want.is_deleted, o_out_item.is_deleted);
                end
            end
        end
    end

    // Valid stays high after a beat unless the next one is preceded by an idle gap.
    task automatic send_item(input logic [1:0] kind, input logic [9:0] slot);
        t_in_item  op;
        t_out_item res;
        op.kind = kind;
        op.slot_index = slot;
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= op;
        do @(posedge i_clk); while (!o_in_ready);
        res = alloc_outcome(op);
        pending_outcomes.push_back(res);
        if (kind == KIND_ACQUIRE && res.status == ST_OK)
            held_slots.push_back(res.acquired_index);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [10:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        entry_limit = value;
    endtask

    task automatic random_ops(input int count, input int acq_pct, input int free_pct);
        int         pick;
        int         k;
        logic [9:0] slot;
        repeat (count) begin
            pick = $urandom_range(99);
            slot = 10'($urandom_range(1023));
            if (pick < acq_pct) begin
                send_item(KIND_ACQUIRE, slot);
            end else if (pick < acq_pct + free_pct) begin
                // Mostly return a held slot; the rest use a random slot, which may be invalid or a double free.
                if (held_slots.size() != 0 && $urandom_range(9) != 0) begin
                    k = $urandom_range(held_slots.size() - 1);
                    slot = held_slots[k];
                    held_slots.delete(k);
                end
                send_item(KIND_FREE, slot);
            end else if (pick < 97) begin
                if (next_fresh > 11'd1 && $urandom_range(9) < 7)
                    slot = 10'($urandom_range(next_fresh - 1, 1));
                send_item(KIND_QUERY, slot);
            end else begin
                send_item(2'd3, slot);
            end
        end
    endtask

    task automatic test_basic_ops();
        send_item(KIND_ACQUIRE, 10'd0);
        send_item(KIND_ACQUIRE, 10'd1023);
        send_item(KIND_ACQUIRE, 10'd5);
        send_item(KIND_QUERY, 10'd1);
        send_item(KIND_FREE, 10'd2);
        send_item(KIND_QUERY, 10'd2);
        send_item(KIND_FREE, 10'd0);
        send_item(KIND_QUERY, 10'd0);
        send_item(KIND_FREE, 10'd1023);
        send_item(KIND_QUERY, 10'd4);
        send_item(2'd3, 10'd1023);
        send_item(KIND_ACQUIRE, 10'd0);
        send_item(KIND_QUERY, 10'd2);
        // Freeing slot 3 twice makes it link to itself.
        send_item(KIND_FREE, 10'd3);
        send_item(KIND_FREE, 10'd3);
        send_item(KIND_ACQUIRE, 10'd0);
        send_item(KIND_ACQUIRE, 10'd0);
        send_item(KIND_ACQUIRE, 10'd0);
        send_item(KIND_FREE, 10'd1);
        send_item(KIND_QUERY, 10'd1);
        drain_results();
        held_slots.delete();
    endtask

    task automatic test_limit_extremes();
        write_limit(11'd0);
        send_item(KIND_ACQUIRE, 10'd0);
        send_item(KIND_ACQUIRE, 10'd0);
        drain_results();
        write_limit(11'd1);
        send_item(KIND_ACQUIRE, 10'd0);
        drain_results();
        // A limit below the number of slots already in use.
        write_limit(11'd2);
        send_item(KIND_FREE, 10'd4);
        send_item(KIND_ACQUIRE, 10'd0);
        send_item(KIND_ACQUIRE, 10'd0);
        drain_results();
    endtask

    task automatic test_backpressure();
        write_limit(11'd64);
        in_idle_pct = 0;
        out_hold_left = 60;
        random_ops(40, 50, 30);
        drain_results();
        in_idle_pct = 12;
    endtask

    task automatic test_random_mix();
        write_limit(11'd40);
        random_ops(250, 55, 30);
        drain_results();
        write_limit(11'($urandom_range(400, 150)));
        random_ops(500, 50, 35);
        drain_results();
        write_limit(11'd2047);
        in_idle_pct = 0;
        out_idle_pct = 0;
        random_ops(100, 50, 30);
        drain_results();
        in_idle_pct = 12;
        out_idle_pct = 12;
    endtask

    task automatic test_fill_table();
        write_limit(MAX_ENTRIES_RST);
        random_ops(1000, 90, 5);
        drain_results();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ops();
        test_limit_extremes();
        test_backpressure();
        test_random_mix();
        test_fill_table();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/sfla_pkg.sv
hdl/sfla_ram.sv
hdl/sfla_core.sv
hdl/slot_free_list_allocator.sv
tb/testbench.sv
